// ===== rtl/nhd_pkg.sv =====
// Shared types and constants for the NRZI HDLC deframer.
// No dependencies; the configuration interface, the scanner and the top level refer to it by scoped names.
package nhd_pkg;

    // event codes carried on the result channel
    typedef enum logic [1:0] {
        EV_DATA = 2'd0,
        EV_DONE = 2'd1,
        EV_DROP = 2'd2
    } event_kind_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SYNC_A  = 2'd0,
        CFG_SYNC_B  = 2'd1,
        CFG_CHANNEL = 2'd2
    } cfg_index_t;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    // register reset values
    localparam logic [15:0] SYNC_A_RESET  = 16'b1010101001111110;
    localparam logic [15:0] SYNC_B_RESET  = 16'b0101010101111110;
    localparam logic        CHANNEL_RESET = 1'b0;

    // framing constants
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [2:0] STUFF_RUN = 3'd5;
    localparam logic [2:0] ABORT_RUN = 3'd7;
    localparam logic [2:0] LAST_BIT  = 3'd7;

    localparam int unsigned MAX_PACKET_BYTES_DEF = 128;

    // one result item
    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  data;
        logic [7:0]  count;
        logic        chan;
    } result_t;

endpackage

// ===== rtl/nhd_rx_if.sv =====
// Receive line channel: one sampled line bit per item.
// Uses no package.
interface nhd_rx_if;
    logic valid;
    logic ready;
    logic line_bit;
    logic transmitting;

    modport source (output valid, output line_bit, output transmitting, input ready);
    modport sink   (input valid, input line_bit, input transmitting, output ready);
endinterface

// ===== rtl/nhd_ev_if.sv =====
// Event channel: data bytes, packet complete and packet dropped items.
// Uses no package.
interface nhd_ev_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] data_byte;
    logic [7:0] byte_count;
    logic       packet_channel;

    modport source (output valid, output event_kind, output data_byte,
                    output byte_count, output packet_channel, input ready);
    modport sink   (input valid, input event_kind, input data_byte,
                    input byte_count, input packet_channel, output ready);
endinterface

// ===== rtl/nhd_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Widths come from nhd_pkg.
interface nhd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [nhd_pkg::CFG_INDEX_W-1:0]  index;
    logic [nhd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/nhd_scanner.sv =====
// Deframer state and per-bit logic: NRZI decode, flag hunt, de-stuffing, bytes.
// Depends on nhd_pkg; driven one bit per step by the top level.
module nhd_scanner #(
    parameter int unsigned MAX_PACKET_BYTES = nhd_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             line_bit,
    input  logic             transmitting,
    input  logic [15:0]      sync_a,
    input  logic [15:0]      sync_b,
    input  logic             channel_tag,
    output logic             res_valid,
    output nhd_pkg::result_t res
);

    localparam logic [7:0] MAX_BYTES = 8'(MAX_PACKET_BYTES);

    logic        prev_bit_reg,     prev_bit_next;
    logic        prev_valid_reg,   prev_valid_next;
    logic [15:0] window_reg,       window_next;
    logic        in_packet_reg,    in_packet_next;
    logic [2:0]  ones_run_reg,     ones_run_next;
    logic [7:0]  byte_shift_reg,   byte_shift_next;
    logic [2:0]  bits_reg,         bits_next;
    logic [7:0]  pkt_bytes_reg,    pkt_bytes_next;
    logic        chan_reg,         chan_next;

    logic        dec;
    logic [15:0] window_shift;
    logic        take_bit;
    logic        clear;

    assign dec          = (prev_bit_reg == line_bit);
    assign window_shift = {window_reg[14:0], dec};

    // per-bit decision
    always_comb
    begin
        prev_bit_next   = prev_bit_reg;
        prev_valid_next = prev_valid_reg;
        window_next     = window_reg;
        in_packet_next  = in_packet_reg;
        ones_run_next   = ones_run_reg;
        byte_shift_next = byte_shift_reg;
        bits_next       = bits_reg;
        pkt_bytes_next  = pkt_bytes_reg;
        chan_next       = chan_reg;
        res_valid       = 1'b0;
        res.kind        = nhd_pkg::EV_DATA;
        res.data        = 8'd0;
        res.count       = pkt_bytes_reg;
        res.chan        = chan_reg;
        take_bit        = 1'b0;
        clear           = 1'b0;

        if (step && !transmitting)
        begin
            if (!prev_valid_reg)
            begin
                // first bit only primes the reference
                prev_bit_next   = line_bit;
                prev_valid_next = 1'b1;
            end
            else if (!in_packet_reg)
            begin
                // hunting for training plus flag
                prev_bit_next = line_bit;
                window_next   = window_shift;
                if (window_shift == sync_a || window_shift == sync_b)
                begin
                    in_packet_next = 1'b1;
                    chan_next      = channel_tag;
                end
            end
            else if (pkt_bytes_reg >= MAX_BYTES || ones_run_reg == nhd_pkg::ABORT_RUN)
            begin
                // packet full or abort run
                res_valid = 1'b1;
                res.kind  = nhd_pkg::EV_DROP;
                clear     = 1'b1;
            end
            else if (window_shift[7:0] == nhd_pkg::FLAG_BYTE)
            begin
                // closing flag
                res_valid = 1'b1;
                res.kind  = nhd_pkg::EV_DONE;
                clear     = 1'b1;
            end
            else
            begin
                prev_bit_next = line_bit;
                window_next   = window_shift;
                if (dec)
                begin
                    ones_run_next = ones_run_reg + 3'd1;
                    take_bit      = 1'b1;
                end
                else
                begin
                    ones_run_next = 3'd0;
                    // stuffed zero after five ones is dropped
                    take_bit      = (ones_run_reg != nhd_pkg::STUFF_RUN);
                end
            end

            // byte assembly, msb first
            if (take_bit)
            begin
                byte_shift_next = {byte_shift_reg[6:0], dec};
                bits_next       = bits_reg + 3'd1;
                if (bits_reg == nhd_pkg::LAST_BIT)
                begin
                    byte_shift_next = 8'd0;
                    pkt_bytes_next  = pkt_bytes_reg + 8'd1;
                    res_valid       = 1'b1;
                    res.kind        = nhd_pkg::EV_DATA;
                    res.data        = {byte_shift_reg[6:0], dec};
                    res.count       = pkt_bytes_reg + 8'd1;
                end
            end

            // back to hunt with everything cleared
            if (clear)
            begin
                prev_bit_next   = 1'b0;
                prev_valid_next = 1'b0;
                window_next     = 16'd0;
                in_packet_next  = 1'b0;
                ones_run_next   = 3'd0;
                byte_shift_next = 8'd0;
                bits_next       = 3'd0;
                pkt_bytes_next  = 8'd0;
                chan_next       = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_bit_reg   <= 1'b0;
            prev_valid_reg <= 1'b0;
            window_reg     <= 16'd0;
            in_packet_reg  <= 1'b0;
            ones_run_reg   <= 3'd0;
            byte_shift_reg <= 8'd0;
            bits_reg       <= 3'd0;
            pkt_bytes_reg  <= 8'd0;
            chan_reg       <= 1'b0;
        end
        else
        begin
            prev_bit_reg   <= prev_bit_next;
            prev_valid_reg <= prev_valid_next;
            window_reg     <= window_next;
            in_packet_reg  <= in_packet_next;
            ones_run_reg   <= ones_run_next;
            byte_shift_reg <= byte_shift_next;
            bits_reg       <= bits_next;
            pkt_bytes_reg  <= pkt_bytes_next;
            chan_reg       <= chan_next;
        end
    end

    // a completed or dropped packet leaves the scanner hunting and unprimed
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind != nhd_pkg::EV_DATA) |=>
        (!in_packet_reg && !prev_valid_reg && pkt_bytes_reg == 8'd0))
        else $error("packet end did not clear scanner state");

    // run of ones is only counted inside a packet
    a_ones_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (ones_run_reg != 3'd0) |-> in_packet_reg)
        else $error("ones run outside packet");

    // byte count never passes the packet limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_bytes_reg <= MAX_BYTES)
        else $error("packet byte count above limit");

    // an emitted data byte restarts the bit counter and shift register
    a_byte_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == nhd_pkg::EV_DATA) |=>
        (bits_reg == 3'd0 && byte_shift_reg == 8'd0))
        else $error("byte assembly not restarted after data byte");

endmodule

// ===== rtl/nrzi_hdlc_deframer.sv =====
// Top level of the NRZI HDLC deframer: input register, scanner, result register,
// configuration registers. Depends on nhd_pkg, the channel interfaces and nhd_scanner.
//
// Usage
//   rx   : one sampled line bit per item, with a transmitting flag; items
//          taken while transmitting is high change nothing.
//   ev   : result items; event_kind data byte, packet complete or packet
//          dropped, with byte count and the channel tag latched at packet start.
//   cfg  : register writes (0 sync pattern a, 1 sync pattern b, 2 channel tag),
//          always ready; write only while no bit is in flight.
// Timing
//   An item is captured in the input register and decoded when it advances;
//   its result, if any, is registered in the output register as the state updates.
//   One item per cycle is sustained while ev is ready; the per-bit state update
//   is one step through the scanner.
// Reset
//   rst_n clears all scanner state (next bit only primes the NRZI reference)
//   and loads the register defaults.
// Stalls
//   While ev is held, the result register keeps its item and one more rx item
//   waits in the input register; rx ready then drops until ev moves again.
module nrzi_hdlc_deframer #(
    parameter int unsigned MAX_PACKET_BYTES = nhd_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    nhd_rx_if.sink    rx,
    nhd_ev_if.source  ev,
    nhd_cfg_if.sink   cfg
);

    logic        in_valid_reg;
    logic        in_bit_reg;
    logic        in_tx_reg;
    logic        advance;

    logic        out_valid_reg;
    nhd_pkg::result_t out_reg;

    logic [15:0] sync_a_reg;
    logic [15:0] sync_b_reg;
    logic        channel_reg;

    logic             res_valid;
    nhd_pkg::result_t res;

    // the held item moves on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || ev.ready);
    assign rx.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_bit_reg <= rx.line_bit;
            in_tx_reg  <= rx.transmitting;
        end
    end

    // per-bit scanner
    nhd_scanner #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_scanner (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .line_bit     (in_bit_reg),
        .transmitting (in_tx_reg),
        .sync_a       (sync_a_reg),
        .sync_b       (sync_b_reg),
        .channel_tag  (channel_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (ev.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign ev.valid          = out_valid_reg;
    assign ev.event_kind     = 2'(out_reg.kind);
    assign ev.data_byte      = out_reg.data;
    assign ev.byte_count     = out_reg.count;
    assign ev.packet_channel = out_reg.chan;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_a_reg  <= nhd_pkg::SYNC_A_RESET;
            sync_b_reg  <= nhd_pkg::SYNC_B_RESET;
            channel_reg <= nhd_pkg::CHANNEL_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (nhd_pkg::cfg_index_t'(cfg.index))
                nhd_pkg::CFG_SYNC_A:  sync_a_reg  <= cfg.data;
                nhd_pkg::CFG_SYNC_B:  sync_b_reg  <= cfg.data;
                nhd_pkg::CFG_CHANNEL: channel_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // a stalled result is never overwritten by a new one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ev.ready) |-> !(advance && res_valid))
        else $error("result register overwritten while stalled");

    // the held item is only dropped by advancing it
    a_input_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input item lost without being processed");

    // a result appears only when the scanner stepped in the prior cycle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && res_valid))
        else $error("result without a processed item");

endmodule
